@@ design/ffa_pkg.sv @@
// shared types and constants of the first-fit free-list allocator
`timescale 1ns / 1ps

package ffa_pkg;

  // fixed field widths
  localparam int unsigned SIZE_W = 17;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned NEED_W = SIZE_W + 1;
  localparam int unsigned KIND_W = 2;

  localparam logic [SIZE_W-1:0] HEAP_SIZE_RESET = SIZE_W'(65536);
  localparam logic [NEED_W-1:0] ALIGN_MASK      = NEED_W'(7);

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_NOP     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_BUMP,
    ST_UNLINK,
    ST_CLEAR,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] address;
    logic              from_free_list;
  } res_t;

endpackage

@@ design/first_fit_free_list_allocator.sv @@
// top level of the first-fit free-list heap allocator
`timescale 1ns / 1ps

// First-fit free-list allocator over byte offsets of a heap. Each input item is
// one request: allocate (kind 0), free (kind 1), restart (kind 2) or no-op
// (kind 3), and each item gives exactly one result item. An allocate rounds the
// size up to 8 bytes, adds HEADER_BYTES, walks the LIFO free list first-fit and
// reuses the first block that is large enough whole; otherwise it bumps from the
// top of the heap, bounded by min(heap_size, HEAP_BYTES). The returned address
// is the offset past the header. Block sizes and list links live in two
// synchronous memories of HEAP_BYTES/8 entries that need no clearing after
// reset. One item is in work at a time. Free, restart and no-op go from IDLE
// straight to RESP. An allocate walks the list in WALK (the link memory gives
// one read per cycle and the next address comes from the data just read), then
// goes through BUMP for a bump or empty list; reuse of the head block goes on
// to RESP, of a later one through UNLINK and CLEAR (unlinking needs two writes
// through the one link write port). A walk stops after MAX_BLOCKS entries and
// then fails. The result register lets the next item be accepted while a
// result still waits on the output. heap_size is to be written only while the
// block is idle; the block does not enforce it. The config port is always ready.
module first_fit_free_list_allocator import ffa_pkg::*; #(
  parameter int unsigned HEAP_BYTES   = 65536,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned MAX_BLOCKS   = 8192
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [SIZE_W-1:0] heap_size_i,
  // request channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [SIZE_W-1:0] request_size_i,
  input  logic [ADDR_W-1:0] free_address_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              ok_o,
  output logic [ADDR_W-1:0] address_o,
  output logic              from_free_list_o
);

  logic [SIZE_W-1:0] heap_size_q;
  logic              out_valid_q, out_valid_d;
  res_t              out_q;
  res_t              ctrl_res;
  logic              ctrl_res_valid;
  logic              out_slot_free;

  // heap limit register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_size_q <= HEAP_SIZE_RESET;
    end else if (cfg_valid_i) begin
      heap_size_q <= heap_size_i;
    end
  end

  // result register can load when empty or being drained this cycle
  assign out_slot_free = !out_valid_q || out_ready_i;

  ffa_ctrl #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (in_valid_i),
    .req_ready_o    (in_ready_o),
    .kind_i         (kind_i),
    .request_size_i (request_size_i),
    .free_address_i (free_address_i),
    .heap_size_i    (heap_size_q),
    .res_valid_o    (ctrl_res_valid),
    .res_take_i     (out_slot_free),
    .res_o          (ctrl_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ctrl_res_valid && out_slot_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (ctrl_res_valid && out_slot_free) begin
      out_q <= ctrl_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign ok_o             = out_q.ok;
  assign address_o        = out_q.address;
  assign from_free_list_o = out_q.from_free_list;

endmodule

@@ design/ffa_ram.sv @@
// single-port-write, single-port-read synchronous memory with registered read data
`timescale 1ns / 1ps

module ffa_ram import ffa_pkg::*; #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned WIDTH = 17,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/ffa_ctrl.sv @@
// request sequencer: list walk, bump allocation, free push and write-back
`timescale 1ns / 1ps

module ffa_ctrl import ffa_pkg::*; #(
  parameter int unsigned HEAP_BYTES   = 65536,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned MAX_BLOCKS   = 8192
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [SIZE_W-1:0] request_size_i,
  input  logic [ADDR_W-1:0] free_address_i,
  input  logic [SIZE_W-1:0] heap_size_i,
  output logic              res_valid_o,
  input  logic              res_take_i,
  output res_t              res_o
);

  localparam int unsigned DEPTH  = HEAP_BYTES / 8;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned LINK_W = IDX_W + 1;
  localparam int unsigned STEP_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [24:0] HEAP_BYTES_W = 25'(HEAP_BYTES);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAX_BLOCKS - 1);

  state_e             state_q, state_d;
  logic [SIZE_W-1:0]  top_q, top_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic               head_valid_q, head_valid_d;
  logic [NEED_W-1:0]  need_q, need_d;
  logic [IDX_W-1:0]   cur_q, cur_d;
  logic [IDX_W-1:0]   prev_q, prev_d;
  logic               have_prev_q, have_prev_d;
  logic [STEP_W-1:0]  steps_q, steps_d;
  logic [LINK_W-1:0]  link_q, link_d;
  res_t               res_q, res_d;

  // memory ports
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [SIZE_W-1:0]  rd_size;
  logic [LINK_W-1:0]  rd_link;
  logic               size_we;
  logic [IDX_W-1:0]   size_waddr;
  logic [SIZE_W-1:0]  size_wdata;
  logic               link_we;
  logic [IDX_W-1:0]   link_waddr;
  logic [LINK_W-1:0]  link_wdata;

  // request decode
  logic [NEED_W-1:0]  need_in;
  logic [ADDR_W-1:0]  free_off;
  logic [31:0]        free_off32;
  logic               free_ok;
  logic [IDX_W-1:0]   free_idx;

  // walk and bump terms
  logic               fit;
  logic [LINK_W-1:0]  link_m1;
  logic               link_ok;
  logic [IDX_W-1:0]   next_idx;
  logic [SIZE_W-1:0]  limit;
  logic [NEED_W-1:0]  room;
  logic               bump_fail;
  logic [31:0]        top32;
  logic               top_slot_ok;
  logic [IDX_W-1:0]   top_idx;

  ffa_ram #(.DEPTH(DEPTH), .WIDTH(SIZE_W)) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (size_we),
    .waddr_i (size_waddr),
    .wdata_i (size_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_size)
  );

  ffa_ram #(.DEPTH(DEPTH), .WIDTH(LINK_W)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_link)
  );

  // round up to 8 and add header
  assign need_in = ((NEED_W'(request_size_i) + ALIGN_MASK) & ~ALIGN_MASK)
                   + NEED_W'(HEADER_BYTES);

  assign free_off   = free_address_i - ADDR_W'(HEADER_BYTES);
  assign free_off32 = 32'(free_off);
  assign free_ok    = (32'(free_address_i) >= 32'(HEADER_BYTES)) &&
                      (free_off[2:0] == 3'd0) &&
                      ((free_off32 >> 3) < 32'(DEPTH));
  assign free_idx   = free_off32[3 +: IDX_W];

  assign fit      = NEED_W'(rd_size) >= need_q;
  assign link_m1  = rd_link - LINK_W'(1);
  assign link_ok  = (rd_link != '0) && (32'(link_m1) < 32'(DEPTH));
  assign next_idx = link_m1[IDX_W-1:0];

  assign limit     = ({8'd0, heap_size_i} < HEAP_BYTES_W) ? heap_size_i
                                                          : HEAP_BYTES_W[SIZE_W-1:0];
  assign room      = NEED_W'(limit) - need_q;
  assign bump_fail = (need_q > NEED_W'(limit)) || (room < NEED_W'(top_q));
  assign top32       = 32'(top_q);
  assign top_slot_ok = (top_q[2:0] == 3'd0) && ((top32 >> 3) < 32'(DEPTH));
  assign top_idx     = top32[3 +: IDX_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      top_q        <= '0;
      head_q       <= '0;
      head_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      top_q        <= top_d;
      head_q       <= head_d;
      head_valid_q <= head_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    need_q      <= need_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    have_prev_q <= have_prev_d;
    steps_q     <= steps_d;
    link_q      <= link_d;
    res_q       <= res_d;
  end

  always_comb begin
    state_d      = state_q;
    top_d        = top_q;
    head_d       = head_q;
    head_valid_d = head_valid_q;
    need_d       = need_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    have_prev_d  = have_prev_q;
    steps_d      = steps_q;
    link_d       = link_q;
    res_d        = res_q;
    rd_en        = 1'b0;
    rd_addr      = head_q;
    size_we      = 1'b0;
    size_waddr   = top_idx;
    size_wdata   = need_q[SIZE_W-1:0];
    link_we      = 1'b0;
    link_waddr   = cur_q;
    link_wdata   = '0;
    req_ready_o  = 1'b0;
    res_valid_o  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          res_d = '{ok: 1'b1, address: '0, from_free_list: 1'b0};
          unique case (kind_e'(kind_i))
            KIND_ALLOC: begin
              need_d      = need_in;
              steps_d     = '0;
              have_prev_d = 1'b0;
              cur_d       = head_q;
              if (head_valid_q) begin
                rd_en   = 1'b1;
                rd_addr = head_q;
                state_d = ST_WALK;
              end else begin
                state_d = ST_BUMP;
              end
            end
            KIND_FREE: begin
              if (free_ok) begin
                link_we      = 1'b1;
                link_waddr   = free_idx;
                link_wdata   = head_valid_q ? ({1'b0, head_q} + LINK_W'(1)) : '0;
                head_d       = free_idx;
                head_valid_d = 1'b1;
              end
              state_d = ST_RESP;
            end
            KIND_RESTART: begin
              top_d        = '0;
              head_d       = '0;
              head_valid_d = 1'b0;
              state_d      = ST_RESP;
            end
            KIND_NOP: begin
              state_d = ST_RESP;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_WALK: begin
        if (fit) begin
          link_d = rd_link;
          res_d  = '{ok: 1'b1,
                     address: ADDR_W'((32'(cur_q) << 3) + 32'(HEADER_BYTES)),
                     from_free_list: 1'b1};
          if (have_prev_q) begin
            state_d = ST_UNLINK;
          end else begin
            head_d       = link_ok ? next_idx : '0;
            head_valid_d = link_ok;
            link_we      = 1'b1;
            link_waddr   = cur_q;
            link_wdata   = '0;
            state_d      = ST_RESP;
          end
        end else if (steps_q == LAST_STEP) begin
          res_d   = '{ok: 1'b0, address: '0, from_free_list: 1'b0};
          state_d = ST_RESP;
        end else if (link_ok) begin
          prev_d      = cur_q;
          have_prev_d = 1'b1;
          cur_d       = next_idx;
          steps_d     = steps_q + STEP_W'(1);
          rd_en       = 1'b1;
          rd_addr     = next_idx;
        end else begin
          state_d = ST_BUMP;
        end
      end

      ST_BUMP: begin
        if (bump_fail) begin
          res_d = '{ok: 1'b0, address: '0, from_free_list: 1'b0};
        end else begin
          top_d = top_q + need_q[SIZE_W-1:0];
          if (top_slot_ok) begin
            size_we    = 1'b1;
            size_waddr = top_idx;
            size_wdata = need_q[SIZE_W-1:0];
            link_we    = 1'b1;
            link_waddr = top_idx;
            link_wdata = '0;
          end
          res_d = '{ok: 1'b1,
                    address: ADDR_W'(top32 + 32'(HEADER_BYTES)),
                    from_free_list: 1'b0};
        end
        state_d = ST_RESP;
      end

      ST_UNLINK: begin
        link_we    = 1'b1;
        link_waddr = prev_q;
        link_wdata = link_q;
        state_d    = ST_CLEAR;
      end

      ST_CLEAR: begin
        link_we    = 1'b1;
        link_waddr = cur_q;
        link_wdata = '0;
        state_d    = ST_RESP;
      end

      ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

endmodule

@@ bench/tb_first_fit_free_list_allocator.sv @@
// testbench for the first-fit free-list heap allocator
`timescale 1ns / 1ps

// Each request is predicted by a behavioral copy of the allocator: heap top,
// free-list head and the per-slot size and link stores, indexed by offset / 8.
// Every predicted reply is queued, and each reply taken from the block is
// compared field by field with the oldest one in the queue.
//
// Flow: directed tests come first. They cover basic allocate, free, restart
// and no-op, the heap_size extremes, the very top of the heap, a list made
// circular by a double free, and a long output hold-off. After that come
// random phases of well-formed traffic with some noise mixed in.
//
// Random frees name only slots whose size entry was already written, apart
// from the ignored ones. A slot that is already on the free list is never
// pushed again, so the list cannot become circular during the random part.
module tb_first_fit_free_list_allocator;
  import ffa_pkg::*;

  localparam int unsigned HEAP_BYTES    = 65536;
  localparam int unsigned HEADER_BYTES  = 16;
  localparam int unsigned MAX_BLOCKS    = 8192;
  localparam int unsigned ALIGN_BYTES   = 8;
  localparam int unsigned SLOTS         = HEAP_BYTES / ALIGN_BYTES;
  localparam int unsigned CLK_PERIOD_NS = 12;
  localparam int unsigned RESET_CYCLES  = 4;
  localparam int unsigned RANDOM_ITEMS  = 1550;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned REPORT_LINES  = 200;

  // how the result side takes replies
  typedef enum logic [1:0] {
    DRAIN_FULL,
    DRAIN_HALF,
    DRAIN_LIGHT,
    DRAIN_SPARSE
  } drain_style_e;

  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b0;
  logic              cfg_valid_i      = 1'b0;
  logic              cfg_ready_o;
  logic [SIZE_W-1:0] heap_size_i      = HEAP_SIZE_RESET;
  logic              in_valid_i       = 1'b0;
  logic              in_ready_o;
  logic [KIND_W-1:0] kind_i           = KIND_NOP;
  logic [SIZE_W-1:0] request_size_i   = '0;
  logic [ADDR_W-1:0] free_address_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i      = 1'b0;
  logic              ok_o;
  logic [ADDR_W-1:0] address_o;
  logic              from_free_list_o;

  // behavioral copy of the allocator state
  int unsigned heap_limit;
  int unsigned heap_top;
  int unsigned free_head;
  bit          free_head_valid;
  int unsigned slot_size [SLOTS];
  int unsigned slot_link [SLOTS];
  bit          slot_sized [SLOTS];
  int unsigned sized_slots[$];

  // replies still owed by the block, oldest first
  res_t        awaited_results[$];
  // addresses handed out in the current random phase and not yet freed
  int unsigned live_blocks[$];

  int unsigned  error_count   = 0;
  int unsigned  cycle_count   = 0;
  int unsigned  burst_left    = 0;
  int unsigned  burst_gap     = 0;
  bit           steady_sender = 1'b0;
  int unsigned  hold_request  = 0;
  int unsigned  hold_left     = 0;
  int unsigned  pattern_left  = 0;
  drain_style_e drain_style   = DRAIN_FULL;

  first_fit_free_list_allocator #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .heap_size_i      (heap_size_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .request_size_i   (request_size_i),
    .free_address_i   (free_address_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .ok_o             (ok_o),
    .address_o        (address_o),
    .from_free_list_o (from_free_list_o)
  );

  always #(CLK_PERIOD_NS / 2) clk_i = ~clk_i;

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    if (error_count < REPORT_LINES) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // predicted reply for one request; updates the state copy on the way
  function automatic res_t allocator_outcome(input kind_e kind, input int unsigned size,
                                             input int unsigned addr);
    res_t        r;
    int unsigned need;
    int unsigned limit;
    int unsigned cur;
    int unsigned prev;
    int unsigned link;
    int unsigned steps;
    int unsigned idx;
    bit          cur_ok;
    bit          have_prev;
    bit          done;
    r.ok             = 1'b1;
    r.address        = '0;
    r.from_free_list = 1'b0;
    case (kind)
      KIND_ALLOC: begin
        need      = ((size + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES + HEADER_BYTES;
        limit     = (heap_limit < HEAP_BYTES) ? heap_limit : HEAP_BYTES;
        cur       = free_head;
        cur_ok    = free_head_valid;
        have_prev = 1'b0;
        prev      = 0;
        done      = 1'b0;
        steps     = 0;
        // first fit along the list; a circular list runs into the step cap
        while (steps < MAX_BLOCKS && cur_ok && !done) begin
          link = slot_link[cur];
          if (slot_size[cur] >= need) begin
            if (have_prev) begin
              slot_link[prev] = link;
            end else if (link != 0) begin
              free_head       = link - 1;
              free_head_valid = 1'b1;
            end else begin
              free_head       = 0;
              free_head_valid = 1'b0;
            end
            slot_link[cur]   = 0;
            r.address        = ADDR_W'(cur * ALIGN_BYTES + HEADER_BYTES);
            r.from_free_list = 1'b1;
            done             = 1'b1;
          end else begin
            have_prev = 1'b1;
            prev      = cur;
            if (link != 0) begin
              cur = link - 1;
            end else begin
              cur_ok = 1'b0;
            end
            steps++;
          end
        end
        if (!done) begin
          if (steps >= MAX_BLOCKS || need > limit || limit - need < heap_top) begin
            r.ok = 1'b0;
          end else begin
            // bump from the top; the new block records its size
            idx      = heap_top / ALIGN_BYTES;
            r.address = ADDR_W'(heap_top + HEADER_BYTES);
            if (heap_top % ALIGN_BYTES == 0 && idx < SLOTS) begin
              slot_size[idx] = need;
              slot_link[idx] = 0;
              if (!slot_sized[idx]) begin
                slot_sized[idx] = 1'b1;
                sized_slots.push_back(idx);
              end
            end
            heap_top += need;
          end
        end
      end
      KIND_FREE: begin
        // addresses below the header or off the 8-byte grid are ignored
        if (addr >= HEADER_BYTES && (addr - HEADER_BYTES) % ALIGN_BYTES == 0 &&
            (addr - HEADER_BYTES) / ALIGN_BYTES < SLOTS) begin
          idx            = (addr - HEADER_BYTES) / ALIGN_BYTES;
          slot_link[idx] = free_head_valid ? free_head + 1 : 0;
          free_head       = idx;
          free_head_valid = 1'b1;
        end
      end
      KIND_RESTART: begin
        heap_top        = 0;
        free_head       = 0;
        free_head_valid = 1'b0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic bit on_free_list(input int unsigned idx);
    int unsigned cur;
    int unsigned steps;
    bit          cur_ok;
    cur    = free_head;
    cur_ok = free_head_valid;
    for (steps = 0; steps < MAX_BLOCKS && cur_ok; steps++) begin
      if (cur == idx) begin
        return 1'b1;
      end
      if (slot_link[cur] != 0) begin
        cur = slot_link[cur] - 1;
      end else begin
        cur_ok = 1'b0;
      end
    end
    return 1'b0;
  endfunction

  // mostly small sizes, sometimes large ones, rarely any 17-bit value
  function automatic int unsigned random_alloc_size();
    case ($urandom_range(0, 19))
      0:       return $urandom_range(0, (1 << SIZE_W) - 1);
      1:       return $urandom_range(0, HEAP_BYTES);
      2, 3:    return $urandom_range(0, 4096);
      default: return $urandom_range(0, 200);
    endcase
  endfunction

  // offer one item in bursts with random gaps; the item is predicted once taken
  task automatic issue_request(input kind_e kind, input int unsigned size,
                               input int unsigned addr, output res_t outcome);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      burst_gap  = steady_sender ? 0 : $urandom_range(0, 9);
      gap        = burst_gap;
    end
    burst_left--;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    request_size_i <= SIZE_W'(size);
    free_address_i <= ADDR_W'(addr);
    do @(posedge clk_i); while (!in_ready_o);
    outcome = allocator_outcome(kind, 32'(SIZE_W'(size)), 32'(ADDR_W'(addr)));
    awaited_results.push_back(outcome);
  endtask

  // stop offering items and wait for every owed reply
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // only called with the block idle
  task automatic write_heap_size(input int unsigned value);
    cfg_valid_i <= 1'b1;
    heap_size_i <= SIZE_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    heap_limit = 32'(SIZE_W'(value));
  endtask

  // result side: long hold-offs on request, otherwise a changing stall pattern
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        drain_style  = drain_style_e'($urandom_range(0, 3));
        pattern_left = $urandom_range(16, 96);
      end
      pattern_left--;
      case (drain_style)
        DRAIN_FULL:  out_ready_i <= 1'b1;
        DRAIN_HALF:  out_ready_i <= 1'($urandom_range(0, 1));
        DRAIN_LIGHT: out_ready_i <= ($urandom_range(0, 7) != 0);
        default:     out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // compare each reply taken with the oldest one owed
  always @(posedge clk_i) begin : reply_check
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        report_error($sformatf("reply with none owed: ok=%0d address=%0d reused=%0d",
                               ok_o, address_o, from_free_list_o));
      end else begin
        want = awaited_results.pop_front();
        if (ok_o !== want.ok || address_o !== want.address ||
            from_free_list_o !== want.from_free_list) begin
          report_error($sformatf("reply ok=%0d address=%0d reused=%0d, expected %0d %0d %0d",
                                 ok_o, address_o, from_free_list_o,
                                 want.ok, want.address, want.from_free_list));
        end
      end
    end
  end

  // allocate, reuse, first fit past a small block, ignored frees, no-op, oversize
  task automatic test_basic_requests();
    res_t r;
    issue_request(KIND_ALLOC, 0, 0, r);
    issue_request(KIND_ALLOC, 1, 0, r);
    issue_request(KIND_ALLOC, 8, 0, r);
    issue_request(KIND_FREE, 0, 16, r);
    issue_request(KIND_ALLOC, 1, 0, r);       // too big for the freed block
    issue_request(KIND_ALLOC, 0, 0, r);       // reuses it
    issue_request(KIND_FREE, 0, 8, r);        // below the header
    issue_request(KIND_FREE, 0, 21, r);       // off the 8-byte grid
    issue_request(KIND_NOP, 1 << 16, 32'h0000_ffff, r);
    issue_request(KIND_FREE, 0, 32, r);
    issue_request(KIND_FREE, 0, 16, r);
    issue_request(KIND_ALLOC, 1, 0, r);       // walks past the head, unlinks behind it
    issue_request(KIND_ALLOC, HEAP_BYTES, 0, r);
    issue_request(KIND_ALLOC, (1 << SIZE_W) - 1, 0, r);
    issue_request(KIND_RESTART, 0, 0, r);
    wait_all_results();
  endtask

  // heap_size extremes, the very top of the heap, and a limit lowered under top
  task automatic test_heap_limits();
    res_t r;
    write_heap_size(0);
    issue_request(KIND_ALLOC, 0, 0, r);
    wait_all_results();
    write_heap_size(24);
    issue_request(KIND_ALLOC, 0, 0, r);
    issue_request(KIND_ALLOC, 0, 0, r);       // eight bytes short of room
    wait_all_results();
    write_heap_size((1 << SIZE_W) - 1);
    issue_request(KIND_RESTART, 0, 0, r);
    issue_request(KIND_ALLOC, HEAP_BYTES - 48, 0, r);
    issue_request(KIND_ALLOC, 0, 0, r);
    issue_request(KIND_ALLOC, 0, 0, r);       // last block, offset wraps to zero
    issue_request(KIND_FREE, 0, HEAP_BYTES - 16, r);
    issue_request(KIND_ALLOC, 0, 0, r);
    wait_all_results();
    write_heap_size(100);
    issue_request(KIND_ALLOC, 0, 0, r);       // bump fails under the lowered limit
    issue_request(KIND_FREE, 0, 16, r);
    issue_request(KIND_ALLOC, 8, 0, r);       // reuse still works
    wait_all_results();
    write_heap_size(HEAP_BYTES);
  endtask

  // a double free makes the list circular; a walk that never fits hits the cap
  task automatic test_corrupt_list();
    res_t r;
    issue_request(KIND_RESTART, 0, 0, r);
    issue_request(KIND_ALLOC, 0, 0, r);
    issue_request(KIND_FREE, 0, 16, r);
    issue_request(KIND_FREE, 0, 16, r);
    issue_request(KIND_ALLOC, 8, 0, r);
    issue_request(KIND_ALLOC, 0, 0, r);
    issue_request(KIND_RESTART, 0, 0, r);
    wait_all_results();
  endtask

  // output held off while items keep coming, so the input must stall
  task automatic test_backpressure();
    res_t r;
    int unsigned n;
    steady_sender = 1'b1;
    hold_request  = HOLD_CYCLES;
    issue_request(KIND_RESTART, 0, 0, r);
    for (n = 0; n < 16; n++) begin
      issue_request(KIND_ALLOC, $urandom_range(0, 64), 0, r);
      if (n % 4 == 3) begin
        issue_request(KIND_FREE, 0, 32'(r.address), r);
      end
    end
    wait_all_results();
    steady_sender = 1'b0;
  endtask

  // phases of well-formed traffic with random content, plus some noise
  task automatic test_random_traffic();
    res_t        r;
    int unsigned sent;
    int unsigned phase_len;
    int unsigned pick;
    int unsigned n;
    int unsigned i;
    int unsigned k;
    int unsigned target;
    bit          hit;
    bit          found;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_all_results();
      case ($urandom_range(0, 5))
        0:       write_heap_size(HEAP_BYTES);
        1:       write_heap_size($urandom_range(0, (1 << SIZE_W) - 1));
        2:       write_heap_size($urandom_range(0, 2048));
        default: begin
        end
      endcase
      steady_sender = ($urandom_range(0, 3) == 0);
      issue_request(KIND_RESTART, $urandom, $urandom, r);
      live_blocks.delete();
      sent++;
      phase_len = $urandom_range(40, 120);
      for (n = 0; n < phase_len; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 38 || (pick < 78 && live_blocks.size() == 0)) begin
          issue_request(KIND_ALLOC, random_alloc_size(), $urandom, r);
          if (r.ok) begin
            live_blocks.push_back(32'(r.address));
          end
          sent++;
        end else if (pick < 78) begin
          // free of a live block, unless that block already sits on the list
          k      = $urandom_range(0, live_blocks.size() - 1);
          target = live_blocks[k];
          live_blocks.delete(k);
          if (target < HEADER_BYTES || !on_free_list((target - HEADER_BYTES) / ALIGN_BYTES)) begin
            issue_request(KIND_FREE, $urandom, target, r);
            sent++;
          end
        end else if (pick < 86) begin
          // ignored free: below the header or off the grid
          target = $urandom_range(0, (1 << ADDR_W) - 1);
          if (target >= HEADER_BYTES) begin
            target = target | (1 << $urandom_range(0, 2));
          end
          issue_request(KIND_FREE, $urandom, target, r);
          sent++;
        end else if (pick < 92) begin
          // foreign free of a sized slot that is neither live nor listed
          found  = 1'b0;
          target = 0;
          for (i = 0; i < 4 && !found && sized_slots.size() != 0; i++) begin
            k      = sized_slots[$urandom_range(0, sized_slots.size() - 1)];
            target = k * ALIGN_BYTES + HEADER_BYTES;
            hit    = 1'b0;
            foreach (live_blocks[j]) begin
              if (live_blocks[j] == target) begin
                hit = 1'b1;
              end
            end
            if (!hit && target < (1 << ADDR_W) && !on_free_list(k)) begin
              found = 1'b1;
            end
          end
          if (found) begin
            issue_request(KIND_FREE, $urandom, target, r);
            sent++;
          end
        end else if (pick < 97) begin
          issue_request(KIND_NOP, $urandom, $urandom, r);
          sent++;
        end else begin
          issue_request(KIND_RESTART, $urandom, $urandom, r);
          live_blocks.delete();
          sent++;
        end
      end
    end
    wait_all_results();
  endtask

  initial begin
    heap_limit      = 32'(HEAP_SIZE_RESET);
    heap_top        = 0;
    free_head       = 0;
    free_head_valid = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_basic_requests();
    test_heap_limits();
    test_corrupt_list();
    test_backpressure();
    test_random_traffic();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
